// ===== src/mtc_pkg.sv =====
// Shared types, constants and calendar helper functions for the millisecond-to-calendar core.
package mtc_pkg;

	localparam int DIV_W = 18;
	localparam int OUT_W = 64;
	localparam int CFG_W = 12;
	localparam int DIGIT_W = 8;
	localparam int RCP_W = 24;
	localparam int RCP_SHIFT = DIV_W + DIGIT_W;

	localparam logic [DIV_W-1:0] DEN_MS_PER_SEC = 18'd1000;
	localparam logic [DIV_W-1:0] DEN_SEC_PER_MIN = 18'd60;
	localparam logic [DIV_W-1:0] DEN_MIN_PER_HR = 18'd60;
	localparam logic [DIV_W-1:0] DEN_HR_PER_DAY = 18'd24;
	localparam logic [DIV_W-1:0] DEN_DAYS_PER_CYCLE = 18'd146097;
	localparam logic [DIV_W-1:0] DEN_DAYS_PER_WEEK = 18'd7;

	// Reciprocals scaled by 2^RCP_SHIFT and rounded down, one per divisor above.
	localparam longint unsigned RCP_ONE = 64'd1 << RCP_SHIFT;
	localparam logic [RCP_W-1:0] RCP_MS_PER_SEC = RCP_W'(RCP_ONE / 64'(DEN_MS_PER_SEC));
	localparam logic [RCP_W-1:0] RCP_SEC_PER_MIN = RCP_W'(RCP_ONE / 64'(DEN_SEC_PER_MIN));
	localparam logic [RCP_W-1:0] RCP_MIN_PER_HR = RCP_W'(RCP_ONE / 64'(DEN_MIN_PER_HR));
	localparam logic [RCP_W-1:0] RCP_HR_PER_DAY = RCP_W'(RCP_ONE / 64'(DEN_HR_PER_DAY));
	localparam logic [RCP_W-1:0] RCP_DAYS_PER_CYCLE =
		RCP_W'(RCP_ONE / 64'(DEN_DAYS_PER_CYCLE));
	localparam logic [RCP_W-1:0] RCP_DAYS_PER_WEEK = RCP_W'(RCP_ONE / 64'(DEN_DAYS_PER_WEEK));

	localparam logic [11:0] YEARS_PER_CYCLE = 12'd400;
	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [3:0] MONTH_JAN = 4'd0;
	localparam logic [3:0] MONTH_FEB = 4'd1;
	localparam logic [3:0] MONTH_DEC = 4'd11;

	typedef struct packed {
		logic [1:0] pad;
		logic leap_flag;
		logic [9:0] millisecond;
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [2:0] weekday;
		logic [4:0] day_of_month;
		logic [3:0] month;
		logic [8:0] day_of_year;
		logic [12:0] year;
	} result_t;

	typedef struct packed {
		logic valid;
		logic ready;
	} hs_t;

	// Leap rule applied to the year reduced modulo 400.
	function automatic logic is_leap(input logic [8:0] yr);
		logic by4;
		logic century;
		by4 = (yr[1:0] == 2'd0);
		century = (yr == 9'd100) || (yr == 9'd200) || (yr == 9'd300);
		return by4 && !century;
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] r;
		case (m)
			4'd0: r = 5'd31;
			4'd1: r = 5'd28;
			4'd2: r = 5'd31;
			4'd3: r = 5'd30;
			4'd4: r = 5'd31;
			4'd5: r = 5'd30;
			4'd6: r = 5'd31;
			4'd7: r = 5'd31;
			4'd8: r = 5'd30;
			4'd9: r = 5'd31;
			4'd10: r = 5'd30;
			4'd11: r = 5'd31;
			default: r = 5'd31;
		endcase
		return r;
	endfunction

	// Month term (13m - 1) / 5 of the weekday congruence, indexed by the zero-based month.
	function automatic logic [4:0] gauss_month_term(input logic [3:0] m);
		logic [4:0] r;
		case (m)
			4'd0: r = 5'd28;
			4'd1: r = 5'd31;
			4'd2: r = 5'd2;
			4'd3: r = 5'd5;
			4'd4: r = 5'd7;
			4'd5: r = 5'd10;
			4'd6: r = 5'd12;
			4'd7: r = 5'd15;
			4'd8: r = 5'd18;
			4'd9: r = 5'd20;
			4'd10: r = 5'd23;
			4'd11: r = 5'd25;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/mtc_div.sv =====
// Shared constant divider by reciprocal multiplication; each radix-256 digit takes MUL, SUB, FIX.
module mtc_div #(
	parameter int COUNT_BITS = 44
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [COUNT_BITS-1:0] num,
	input logic [mtc_pkg::DIV_W-1:0] den,
	input logic [mtc_pkg::RCP_W-1:0] rcp,
	output logic done,
	output logic [COUNT_BITS-1:0] quot,
	output logic [mtc_pkg::DIV_W-1:0] rem
);

	localparam int DIGITS = (COUNT_BITS + mtc_pkg::DIGIT_W - 1) / mtc_pkg::DIGIT_W;
	localparam int NUM_W = DIGITS * mtc_pkg::DIGIT_W;
	localparam int CNT_W = $clog2(DIGITS + 1);
	localparam int X_W = mtc_pkg::DIV_W + mtc_pkg::DIGIT_W;
	localparam int P_W = X_W + mtc_pkg::RCP_W;

	typedef enum logic [2:0] {
		PH_MUL = 3'b001,
		PH_SUB = 3'b010,
		PH_FIX = 3'b100
	} phase_t;

	logic busy_q;
	logic done_q;
	phase_t phase_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0] num_q;
	logic [mtc_pkg::DIV_W-1:0] den_q;
	logic [mtc_pkg::RCP_W-1:0] rcp_q;
	logic [mtc_pkg::DIV_W-1:0] rem_q;
	logic [mtc_pkg::DIGIT_W-1:0] qe_q;
	logic [X_W-1:0] rt_q;

	logic [X_W-1:0] x;
	logic [P_W-1:0] prod;
	logic [X_W-1:0] den_x;
	logic [X_W-1:0] back;
	logic fix;

	// The partial remainder stays below the divisor, so each digit is at most 255 and the
	// estimate from the rounded-down reciprocal is short by at most one.
	assign x = {rem_q, num_q[NUM_W-1 -: mtc_pkg::DIGIT_W]};
	assign prod = x * rcp_q;
	assign den_x = {{(X_W - mtc_pkg::DIV_W){1'b0}}, den_q};
	assign back = {{(X_W - mtc_pkg::DIGIT_W){1'b0}}, qe_q} * den_x;
	assign fix = (rt_q >= den_x);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			phase_q <= PH_MUL;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				phase_q <= PH_MUL;
				cnt_q <= CNT_W'(DIGITS);
			end else if (busy_q) begin
				case (phase_q)
					PH_MUL: begin
						phase_q <= PH_SUB;
					end
					PH_SUB: begin
						phase_q <= PH_FIX;
					end
					PH_FIX: begin
						phase_q <= PH_MUL;
						cnt_q <= cnt_q - CNT_W'(1);
						if (cnt_q == CNT_W'(1)) begin
							busy_q <= 1'b0;
							done_q <= 1'b1;
						end
					end
					default: begin
						phase_q <= PH_MUL;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NUM_W'(num);
			den_q <= den;
			rcp_q <= rcp;
			rem_q <= '0;
		end else if (busy_q) begin
			case (phase_q)
				PH_MUL: begin
					qe_q <= mtc_pkg::DIGIT_W'(prod >> X_W);
				end
				PH_SUB: begin
					rt_q <= x - back;
				end
				PH_FIX: begin
					if (fix) begin
						rem_q <= mtc_pkg::DIV_W'(rt_q - den_x);
						num_q <= {num_q[NUM_W-mtc_pkg::DIGIT_W-1:0],
							qe_q + mtc_pkg::DIGIT_W'(1)};
					end else begin
						rem_q <= rt_q[mtc_pkg::DIV_W-1:0];
						num_q <= {num_q[NUM_W-mtc_pkg::DIGIT_W-1:0], qe_q};
					end
				end
				default: begin
					qe_q <= qe_q;
				end
			endcase
		end
	end

	assign done = done_q;
	assign quot = num_q[COUNT_BITS-1:0];
	assign rem = rem_q;

endmodule

// ===== src/mtc_ctrl.sv =====
// Sequencer that walks one count through the divider, the year and month loops and the weekday.
module mtc_ctrl #(
	parameter int COUNT_BITS = 44
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [COUNT_BITS-1:0] millis,
	input logic [mtc_pkg::CFG_W-1:0] start_year,
	output logic idle,
	output mtc_pkg::hs_t res_hs_out,
	input logic res_ready,
	output mtc_pkg::result_t result,
	output logic div_start,
	output logic [COUNT_BITS-1:0] div_num,
	output logic [mtc_pkg::DIV_W-1:0] div_den,
	output logic [mtc_pkg::RCP_W-1:0] div_rcp,
	input logic div_done,
	input logic [COUNT_BITS-1:0] div_quot,
	input logic [mtc_pkg::DIV_W-1:0] div_rem
);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_DIV = 8'b0000_0010,
		S_Y400 = 8'b0000_0100,
		S_YEAR = 8'b0000_1000,
		S_MONTH = 8'b0001_0000,
		S_GAUSS = 8'b0010_0000,
		S_WSTART = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	typedef enum logic [2:0] {
		STG_MS = 3'd0,
		STG_SEC = 3'd1,
		STG_MIN = 3'd2,
		STG_HOUR = 3'd3,
		STG_CYC = 3'd4,
		STG_WDAY = 3'd5
	} stage_t;

	state_t state_q;
	stage_t stage_q;
	logic div_start_q;
	logic [COUNT_BITS-1:0] div_num_q;
	logic [mtc_pkg::DIV_W-1:0] div_den_q;
	logic [mtc_pkg::RCP_W-1:0] div_rcp_q;

	logic [9:0] msec_q;
	logic [5:0] sec_q;
	logic [5:0] min_q;
	logic [4:0] hour_q;
	logic [mtc_pkg::DIV_W-1:0] days_q;
	logic [12:0] year_q;
	logic [11:0] yr_q;
	logic [8:0] doy_q;
	logic [8:0] dom_q;
	logic [3:0] month_q;
	logic [2:0] c_q;
	logic [6:0] d_q;
	logic [2:0] wday_q;

	logic leap;
	logic [8:0] ylen;
	logic year_more;
	logic [4:0] mlen;
	logic month_more;
	logic [9:0] yp;
	logic [2:0] cent;
	logic [9:0] cent_base;
	logic [7:0] gauss_n;

	assign leap = mtc_pkg::is_leap(yr_q[8:0]);
	assign ylen = mtc_pkg::DAYS_PER_YEAR + {8'd0, leap};
	assign year_more = (days_q >= {{(mtc_pkg::DIV_W - 9){1'b0}}, ylen});
	assign mlen = mtc_pkg::month_len(month_q) +
		{4'd0, (month_q == mtc_pkg::MONTH_FEB) && leap};
	assign month_more = (dom_q >= {4'd0, mlen}) && (month_q < mtc_pkg::MONTH_DEC);

	assign yp = {1'b0, yr_q[8:0]} + 10'd400 - {9'd0, month_q < mtc_pkg::MONTH_FEB + 4'd1};

	always_comb begin
		if (yp >= 10'd700) begin
			cent = 3'd7;
		end else if (yp >= 10'd600) begin
			cent = 3'd6;
		end else if (yp >= 10'd500) begin
			cent = 3'd5;
		end else if (yp >= 10'd400) begin
			cent = 3'd4;
		end else begin
			cent = 3'd3;
		end
		cent_base = 10'(cent * 10'd100);
	end

	assign gauss_n = 8'(dom_q[4:0]) + 8'd1 + 8'(mtc_pkg::gauss_month_term(month_q)) +
		8'(d_q) + 8'(d_q[6:2]) + 8'(c_q[2]) + 8'(c_q * 6'd5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			stage_q <= STG_MS;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_DIV;
						stage_q <= STG_MS;
						div_start_q <= 1'b1;
					end
				end
				S_DIV: begin
					if (div_done) begin
						case (stage_q)
							STG_MS: begin
								stage_q <= STG_SEC;
								div_start_q <= 1'b1;
							end
							STG_SEC: begin
								stage_q <= STG_MIN;
								div_start_q <= 1'b1;
							end
							STG_MIN: begin
								stage_q <= STG_HOUR;
								div_start_q <= 1'b1;
							end
							STG_HOUR: begin
								stage_q <= STG_CYC;
								div_start_q <= 1'b1;
							end
							STG_CYC: begin
								state_q <= S_Y400;
							end
							STG_WDAY: begin
								state_q <= S_DONE;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_Y400: begin
					if (yr_q < mtc_pkg::YEARS_PER_CYCLE) begin
						state_q <= S_YEAR;
					end
				end
				S_YEAR: begin
					if (!year_more) begin
						state_q <= S_MONTH;
					end
				end
				S_MONTH: begin
					if (!month_more) begin
						state_q <= S_GAUSS;
					end
				end
				S_GAUSS: begin
					state_q <= S_WSTART;
				end
				S_WSTART: begin
					state_q <= S_DIV;
					stage_q <= STG_WDAY;
					div_start_q <= 1'b1;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (start) begin
					div_num_q <= millis;
					div_den_q <= mtc_pkg::DEN_MS_PER_SEC;
					div_rcp_q <= mtc_pkg::RCP_MS_PER_SEC;
				end
			end
			S_DIV: begin
				if (div_done) begin
					case (stage_q)
						STG_MS: begin
							msec_q <= div_rem[9:0];
							div_num_q <= div_quot;
							div_den_q <= mtc_pkg::DEN_SEC_PER_MIN;
							div_rcp_q <= mtc_pkg::RCP_SEC_PER_MIN;
						end
						STG_SEC: begin
							sec_q <= div_rem[5:0];
							div_num_q <= div_quot;
							div_den_q <= mtc_pkg::DEN_MIN_PER_HR;
							div_rcp_q <= mtc_pkg::RCP_MIN_PER_HR;
						end
						STG_MIN: begin
							min_q <= div_rem[5:0];
							div_num_q <= div_quot;
							div_den_q <= mtc_pkg::DEN_HR_PER_DAY;
							div_rcp_q <= mtc_pkg::RCP_HR_PER_DAY;
						end
						STG_HOUR: begin
							hour_q <= div_rem[4:0];
							div_num_q <= div_quot;
							div_den_q <= mtc_pkg::DEN_DAYS_PER_CYCLE;
							div_rcp_q <= mtc_pkg::RCP_DAYS_PER_CYCLE;
						end
						STG_CYC: begin
							days_q <= div_rem;
							year_q <= {1'b0, start_year} + 13'(div_quot[12:0] * 13'd400);
							yr_q <= start_year;
						end
						STG_WDAY: begin
							wday_q <= (div_rem[2:0] == 3'd0) ? 3'd6 : 3'(div_rem[2:0] - 3'd1);
						end
						default: begin
							wday_q <= 3'd0;
						end
					endcase
				end
			end
			S_Y400: begin
				if (yr_q >= mtc_pkg::YEARS_PER_CYCLE) begin
					yr_q <= yr_q - mtc_pkg::YEARS_PER_CYCLE;
				end
			end
			S_YEAR: begin
				if (year_more) begin
					days_q <= days_q - {{(mtc_pkg::DIV_W - 9){1'b0}}, ylen};
					year_q <= year_q + 13'd1;
					yr_q <= (yr_q == 12'd399) ? 12'd0 : yr_q + 12'd1;
				end else begin
					doy_q <= days_q[8:0];
					dom_q <= days_q[8:0];
					month_q <= mtc_pkg::MONTH_JAN;
				end
			end
			S_MONTH: begin
				if (month_more) begin
					dom_q <= dom_q - {4'd0, mlen};
					month_q <= month_q + 4'd1;
				end
			end
			S_GAUSS: begin
				c_q <= cent;
				d_q <= 7'(yp - cent_base);
			end
			S_WSTART: begin
				div_num_q <= COUNT_BITS'(gauss_n);
				div_den_q <= mtc_pkg::DEN_DAYS_PER_WEEK;
				div_rcp_q <= mtc_pkg::RCP_DAYS_PER_WEEK;
			end
			default: begin
				d_q <= d_q;
			end
		endcase
	end

	assign idle = (state_q == S_IDLE);
	assign res_hs_out.valid = (state_q == S_DONE);
	assign res_hs_out.ready = res_ready;

	assign div_start = div_start_q;
	assign div_num = div_num_q;
	assign div_den = div_den_q;
	assign div_rcp = div_rcp_q;

	always_comb begin
		result.pad = 2'd0;
		result.leap_flag = leap;
		result.millisecond = msec_q;
		result.second = sec_q;
		result.minute = min_q;
		result.hour = hour_q;
		result.weekday = wday_q;
		result.day_of_month = dom_q[4:0];
		result.month = month_q;
		result.day_of_year = doy_q;
		result.year = year_q;
	end

endmodule

// ===== src/millis_to_calendar_fields_core.sv =====
// Top level of the millisecond-count to Gregorian calendar fields converter.
//
// Channel  Direction  Transfer when           Payload
// s_*      in         s_tvalid & s_tready     millis_count
// m_*      out        m_tvalid & m_tready     year .. leap_flag
// cfg_*    in         cfg_valid & cfg_ready   start_year
//
// One transaction takes six passes through the shared divider, a reduction of the start year
// modulo 400 by repeated subtraction, up to 400 year steps and up to 12 month steps; the year
// loop dominates the worst case.
// Reset is asynchronous and sets start_year to 1970. s_tready is low while a count is in
// work, and a finished result waits in the output register until m_tready takes it.
module millis_to_calendar_fields_core #(
	parameter int COUNT_BITS = 44
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// Bits from 0: millis_count, zero fill to whole bytes.
	input logic [((COUNT_BITS + 7) / 8) * 8 - 1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// Bits from 0: year, day_of_year, month, day_of_month, weekday, hour, minute, second,
	// millisecond, leap_flag, zero fill.
	output logic [mtc_pkg::OUT_W-1:0] m_tdata,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [mtc_pkg::CFG_W-1:0] cfg_data
);

	logic [mtc_pkg::CFG_W-1:0] start_year_q;
	logic out_valid_q;
	mtc_pkg::result_t out_data_q;

	logic idle;
	logic accept;
	logic res_ready;
	mtc_pkg::hs_t res_hs;
	mtc_pkg::result_t result;

	logic div_start;
	logic [COUNT_BITS-1:0] div_num;
	logic [mtc_pkg::DIV_W-1:0] div_den;
	logic [mtc_pkg::RCP_W-1:0] div_rcp;
	logic div_done;
	logic [COUNT_BITS-1:0] div_quot;
	logic [mtc_pkg::DIV_W-1:0] div_rem;

	assign s_tready = idle;
	assign accept = s_tvalid && idle;
	assign cfg_ready = 1'b1;
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_year_q <= 12'd1970;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				start_year_q <= cfg_data;
			end
			if (res_hs.valid && res_ready) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_hs.valid && res_ready) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = out_data_q;

	mtc_ctrl #(
		.COUNT_BITS(COUNT_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(accept),
		.millis(s_tdata[COUNT_BITS-1:0]),
		.start_year(start_year_q),
		.idle(idle),
		.res_hs_out(res_hs),
		.res_ready(res_ready),
		.result(result),
		.div_start(div_start),
		.div_num(div_num),
		.div_den(div_den),
		.div_rcp(div_rcp),
		.div_done(div_done),
		.div_quot(div_quot),
		.div_rem(div_rem)
	);

	mtc_div #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(div_num),
		.den(div_den),
		.rcp(div_rcp),
		.done(div_done),
		.quot(div_quot),
		.rem(div_rem)
	);

endmodule
